[hdl/sme_pkg.sv]
package sme_pkg;

    localparam int STACK_WORDS   = 128;
    localparam int PROGRAM_WORDS = 1024;
    localparam int WORD_W        = 64;
    localparam int HALF_W        = WORD_W / 2;
    localparam int SP_W          = $clog2(STACK_WORDS);
    localparam int DEPTH_W       = 8;
    localparam int PC_W          = 11;
    localparam int LEN_W         = 11;
    localparam int OP_W          = 4;
    localparam int TRAP_W        = 3;
    localparam int CNT_W         = $clog2(WORD_W);
    localparam int MUL_LAST      = 3;
    localparam int DIV_LAST      = WORD_W - 1;
    localparam int OUT_W         = TRAP_W + 1 + PC_W + DEPTH_W + WORD_W;
    localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_NOP   = 4'd0,
        OP_PUSH  = 4'd1,
        OP_DUP   = 4'd2,
        OP_PLUS  = 4'd3,
        OP_MINUS = 4'd4,
        OP_MULT  = 4'd5,
        OP_DIV   = 4'd6,
        OP_JMP   = 4'd7,
        OP_HALT  = 4'd8,
        OP_JMPIF = 4'd9,
        OP_EQ    = 4'd10
    } t_op;

    typedef enum logic [TRAP_W-1:0] {
        TRAP_OK      = 3'd0,
        TRAP_OVER    = 3'd1,
        TRAP_UNDER   = 3'd2,
        TRAP_OPCODE  = 3'd3,
        TRAP_DIVZERO = 3'd4,
        TRAP_JUMP    = 3'd5,
        TRAP_OPERAND = 3'd6
    } t_trap;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic trap_any;
        logic mul_last;
        logic div_last;
    } t_stat;

endpackage

[hdl/stack_machine_execute.sv]
// An accepted beat is registered, its operands are read from the stack
// memory and its result is committed to the output register; mult runs 4
// multiplier steps and div a setup step and 64 divider steps between the read
// and the commit. A new beat is taken only when the previous one commits, and
// a commit waits while the output register is full and not being read.
// Reset (i_rst_n low, synchronous) empties the stack, clears the pointer and
// halt flag and sets the program length to 1024; stack contents are kept.
module stack_machine_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [63:0] operand
    input  logic [3:0]  s_axis_tuser,  // [3:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] trap, [3] halted, [14:4] next_pointer, [22:15] depth,
    // [86:23] top_value, [87] zero
    output logic [87:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data
);
    import sme_pkg::*;

    t_cmd               cmd;
    t_stat              stat;
    logic [TRAP_W-1:0]  trap;
    logic               halted;
    logic [PC_W-1:0]    next_pointer;
    logic [DEPTH_W-1:0] depth;
    logic [WORD_W-1:0]  top_value;

    sme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sme_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (s_axis_tuser),
        .i_operand      (s_axis_tdata),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_trap         (trap),
        .o_halted       (halted),
        .o_next_pointer (next_pointer),
        .o_depth        (depth),
        .o_top_value    (top_value)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}},
                           top_value, depth, next_pointer, halted, trap};

endmodule

[hdl/sme_ctrl.sv]
module sme_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sme_pkg::t_stat i_stat,
    output sme_pkg::t_cmd  o_cmd
);
    import sme_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.trap_any) n_state = S_COMMIT;
                else if (i_stat.op == OP_MULT) n_state = S_MUL;
                else if (i_stat.op == OP_DIV) n_state = S_DIV_INIT;
                else n_state = S_COMMIT;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) n_state = S_COMMIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                // The next item is taken in the same cycle the result retires.
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    o_in_ready   = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit while result register is occupied");

    a_load_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_READ))
        else $error("accepted beat did not start a stack read");

    a_div_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_stat.div_last) |=> (r_state == S_DIV))
        else $error("divider left before its last step");

    a_ready_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE || r_state == S_COMMIT))
        else $error("ready raised while an item is in flight");

endmodule

[hdl/sme_dpath.sv]
module sme_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sme_pkg::t_cmd                        i_cmd,
    output sme_pkg::t_stat                       o_stat,
    input  logic [sme_pkg::OP_W-1:0]            i_operation,
    input  logic [sme_pkg::WORD_W-1:0]          i_operand,
    input  logic                                i_cfg_wr_en,
    input  logic [sme_pkg::LEN_W-1:0]           i_cfg_wr_data,
    output logic [sme_pkg::TRAP_W-1:0]          o_trap,
    output logic                                o_halted,
    output logic [sme_pkg::PC_W-1:0]            o_next_pointer,
    output logic [sme_pkg::DEPTH_W-1:0]         o_depth,
    output logic [sme_pkg::WORD_W-1:0]          o_top_value
);
    import sme_pkg::*;

    t_op                r_op;
    logic [WORD_W-1:0]  r_opd;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [PC_W-1:0]    r_pc, n_pc;
    logic               r_halt, n_halt;
    logic [LEN_W-1:0]   r_plen;
    logic [WORD_W-1:0]  r_tos, n_tos;

    logic [WORD_W-1:0]  mem [STACK_WORDS];
    logic [WORD_W-1:0]  r_rdata;
    logic [SP_W-1:0]    rd_addr, wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               wr_en;

    logic [CNT_W-1:0]   r_cnt;
    logic [WORD_W-1:0]  r_prod, r_acc;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [WORD_W-1:0]  mul_p;

    logic [WORD_W-1:0]  r_rem, r_quo, r_dvs;
    logic               r_qneg;
    logic [WORD_W:0]    div_t;
    logic               div_ge;

    logic [LEN_W-1:0]   lim;
    logic               jump_ok;
    logic               full;
    t_trap              trap;
    logic [DEPTH_W-1:0] dup_idx, sec_idx;
    logic [PC_W-1:0]    pc_inc;
    logic [WORD_W-1:0]  bin_res;

    // Operation and operand registers; configuration and architectural state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_opd <= i_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_plen  <= LEN_W'(PROGRAM_WORDS);
        end else begin
            if (i_cfg_wr_en) r_plen <= i_cfg_wr_data;
            if (i_cmd.commit) begin
                r_depth <= n_depth;
                r_pc    <= n_pc;
                r_halt  <= n_halt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_tos <= n_tos;
    end

    // Trap checks, all from registered values.
    assign lim     = (r_plen > LEN_W'(PROGRAM_WORDS)) ? LEN_W'(PROGRAM_WORDS) : r_plen;
    assign jump_ok = !r_opd[WORD_W-1] && (r_opd < WORD_W'(lim));
    assign full    = r_depth >= DEPTH_W'(STACK_WORDS);

    always_comb begin
        trap = TRAP_OK;
        case (r_op)
            OP_NOP, OP_HALT: trap = TRAP_OK;
            OP_PUSH: if (full) trap = TRAP_OVER;
            OP_DUP: begin
                if (full) trap = TRAP_OVER;
                else if (r_opd[WORD_W-1]) trap = TRAP_OPERAND;
                else if (r_opd >= WORD_W'(r_depth)) trap = TRAP_UNDER;
            end
            OP_PLUS, OP_MINUS, OP_MULT, OP_EQ: begin
                if (r_depth < DEPTH_W'(2)) trap = TRAP_UNDER;
            end
            OP_DIV: begin
                if (r_depth < DEPTH_W'(2)) trap = TRAP_UNDER;
                else if (r_tos == '0) trap = TRAP_DIVZERO;
            end
            OP_JMP: if (!jump_ok) trap = TRAP_JUMP;
            OP_JMPIF: begin
                if (r_depth == '0) trap = TRAP_UNDER;
                else if (!jump_ok) trap = TRAP_JUMP;
            end
            default: trap = TRAP_OPCODE;
        endcase
    end

    assign o_stat.op       = r_op;
    assign o_stat.trap_any = (trap != TRAP_OK);
    assign o_stat.mul_last = (r_cnt == CNT_W'(MUL_LAST));
    assign o_stat.div_last = (r_cnt == CNT_W'(DIV_LAST));

    // Stack memory mirrors every entry, the top one included.
    assign dup_idx = r_depth - DEPTH_W'(1) - r_opd[DEPTH_W-1:0];
    assign sec_idx = r_depth - DEPTH_W'(2);
    assign rd_addr = (r_op == OP_DUP) ? dup_idx[SP_W-1:0] : sec_idx[SP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en && i_cmd.commit) mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rdata <= mem[rd_addr];
    end

    // Low 64 bits of the product from three 32x32 partial products.
    always_comb begin
        case (r_cnt[1:0])
            2'd1: begin
                mul_a = r_rdata[HALF_W-1:0];
                mul_b = r_tos[WORD_W-1:HALF_W];
            end
            2'd2: begin
                mul_a = r_rdata[WORD_W-1:HALF_W];
                mul_b = r_tos[HALF_W-1:0];
            end
            default: begin
                mul_a = r_rdata[HALF_W-1:0];
                mul_b = r_tos[HALF_W-1:0];
            end
        endcase
    end
    assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign div_t  = {r_rem, r_quo[WORD_W-1]};
    assign div_ge = div_t >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cnt <= '0;
        end else if (i_cmd.mul_step || i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.mul_step) begin
            r_prod <= mul_p;
            if (r_cnt == CNT_W'(1)) r_acc <= r_prod;
            else if (r_cnt != '0) r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        if (i_cmd.div_init) begin
            r_qneg <= r_rdata[WORD_W-1] ^ r_tos[WORD_W-1];
            r_quo  <= r_rdata[WORD_W-1] ? -r_rdata : r_rdata;
            r_dvs  <= r_tos[WORD_W-1] ? -r_tos : r_tos;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? WORD_W'(div_t - {1'b0, r_dvs}) : div_t[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], div_ge};
        end
    end

    always_comb begin
        case (r_op)
            OP_PLUS:  bin_res = r_rdata + r_tos;
            OP_MINUS: bin_res = r_rdata - r_tos;
            OP_MULT:  bin_res = r_acc;
            OP_DIV:   bin_res = r_qneg ? -r_quo : r_quo;
            OP_EQ:    bin_res = WORD_W'(r_rdata == r_tos);
            default:  bin_res = '0;
        endcase
    end

    assign pc_inc = r_pc + PC_W'(1);

    always_comb begin
        n_depth = r_depth;
        n_pc    = r_pc;
        n_halt  = r_halt;
        n_tos   = r_tos;
        wr_en   = 1'b0;
        wr_addr = r_depth[SP_W-1:0];
        wr_data = r_opd;
        if (trap == TRAP_OK) begin
            case (r_op)
                OP_NOP: n_pc = pc_inc;
                OP_PUSH: begin
                    wr_en   = 1'b1;
                    n_tos   = r_opd;
                    n_depth = r_depth + DEPTH_W'(1);
                    n_pc    = pc_inc;
                end
                OP_DUP: begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata;
                    n_tos   = r_rdata;
                    n_depth = r_depth + DEPTH_W'(1);
                    n_pc    = pc_inc;
                end
                OP_PLUS, OP_MINUS, OP_MULT, OP_DIV, OP_EQ: begin
                    wr_en   = 1'b1;
                    wr_addr = sec_idx[SP_W-1:0];
                    wr_data = bin_res;
                    n_tos   = bin_res;
                    n_depth = r_depth - DEPTH_W'(1);
                    n_pc    = pc_inc;
                end
                OP_JMP: n_pc = r_opd[PC_W-1:0];
                OP_HALT: n_halt = 1'b1;
                OP_JMPIF: begin
                    if (r_tos != '0) begin
                        n_depth = r_depth - DEPTH_W'(1);
                        n_tos   = r_rdata;
                        n_pc    = r_opd[PC_W-1:0];
                    end else begin
                        n_pc = pc_inc;
                    end
                end
                default: n_pc = r_pc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_trap         <= trap;
            o_halted       <= n_halt;
            o_next_pointer <= n_pc;
            o_depth        <= n_depth;
            o_top_value    <= (n_depth == '0) ? '0 : n_tos;
        end
    end

endmodule
